// ===== rtl/core/combined_tausworthe_rng_core_defines.svh =====
// Assertion macros for the checker file of the RNG core.
// No dependencies; included by bare file name.
`ifndef COMBINED_TAUSWORTHE_RNG_CORE_DEFINES_SVH
`define COMBINED_TAUSWORTHE_RNG_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CTRNG_ASSERT_IMP(label, clk, rst_n, ant, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ant) |-> (cons)) \
        else $error("ctrng assertion failed");

// Next-cycle implication, disabled during reset.
`define CTRNG_ASSERT_NXT(label, clk, rst_n, ant, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ant) |=> (cons)) \
        else $error("ctrng assertion failed");

`endif

// ===== rtl/core/ctrng_pkg.sv =====
// Shared types and constants for the combined Tausworthe RNG core.
// No dependencies.
package ctrng_pkg;

    localparam logic OP_DRAW   = 1'b0;
    localparam logic OP_RESEED = 1'b1;

    localparam logic [31:0] LcgMult   = 32'd69069;
    localparam int          WarmSteps = 6;
    localparam int          WarmW     = $clog2(WarmSteps);

    localparam logic [31:0] MinA = 32'd1;
    localparam logic [31:0] MinB = 32'd7;
    localparam logic [31:0] MinC = 32'd15;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_SEED_A = 8'b0000_0010,
        ST_MUL_B  = 8'b0000_0100,
        ST_SEED_B = 8'b0000_1000,
        ST_MUL_C  = 8'b0001_0000,
        ST_SEED_C = 8'b0010_0000,
        ST_WARM   = 8'b0100_0000,
        ST_DRAW   = 8'b1000_0000
    } state_t;

    typedef struct packed {
        logic mul_seed;  // product <= seed * mult
        logic mul_a;     // product <= comp_a * mult
        logic mul_b;     // product <= comp_b * mult
        logic load_a;
        logic load_b;
        logic load_c;
        logic advance;   // one Tausworthe step on all three components
        logic load_out;  // capture the advanced XOR into the output register
    } cmd_t;

endpackage

// ===== rtl/core/ctrng_dpath.sv =====
// Datapath: component registers, shared LCG multiplier, output register.
// Depends on ctrng_pkg.
module ctrng_dpath (
    input  logic                aclk,
    input  logic                aresetn,
    input  ctrng_pkg::cmd_t     cmd,
    input  logic [31:0]         seed_value,
    output logic [31:0]         random_value
);
    import ctrng_pkg::*;

    logic [31:0] comp_a_reg, comp_a_next;
    logic [31:0] comp_b_reg, comp_b_next;
    logic [31:0] comp_c_reg, comp_c_next;
    logic [31:0] prod_reg, prod_next;
    logic [31:0] out_reg, out_next;
    logic [31:0] mul_operand;
    logic [31:0] step_a, step_b, step_c;

    function automatic logic [31:0] lift_min(input logic [31:0] x, input logic [31:0] m);
        return (x < m) ? x + m : x;
    endfunction

    // Fixed shift amounts per component; mask clears the low bits first.
    assign step_a = ((comp_a_reg & 32'hFFFF_FFFE) << 12)
                  ^ (((comp_a_reg << 13) ^ comp_a_reg) >> 19);
    assign step_b = ((comp_b_reg & 32'hFFFF_FFF8) << 4)
                  ^ (((comp_b_reg << 2) ^ comp_b_reg) >> 25);
    assign step_c = ((comp_c_reg & 32'hFFFF_FFF0) << 17)
                  ^ (((comp_c_reg << 3) ^ comp_c_reg) >> 11);

    always_comb begin
        if (cmd.mul_seed) begin
            mul_operand = seed_value;
        end else if (cmd.mul_a) begin
            mul_operand = comp_a_reg;
        end else begin
            mul_operand = comp_b_reg;
        end
    end

    always_comb begin
        prod_next   = prod_reg;
        comp_a_next = comp_a_reg;
        comp_b_next = comp_b_reg;
        comp_c_next = comp_c_reg;
        out_next    = out_reg;
        if (cmd.mul_seed || cmd.mul_a || cmd.mul_b) begin
            prod_next = mul_operand * LcgMult;
        end
        if (cmd.advance) begin
            comp_a_next = step_a;
            comp_b_next = step_b;
            comp_c_next = step_c;
        end
        if (cmd.load_a) begin
            comp_a_next = lift_min(prod_reg, MinA);
        end
        if (cmd.load_b) begin
            comp_b_next = lift_min(prod_reg, MinB);
        end
        if (cmd.load_c) begin
            comp_c_next = lift_min(prod_reg, MinC);
        end
        if (cmd.load_out) begin
            out_next = step_a ^ step_b ^ step_c;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            comp_a_reg <= '0;
            comp_b_reg <= '0;
            comp_c_reg <= '0;
        end else begin
            comp_a_reg <= comp_a_next;
            comp_b_reg <= comp_b_next;
            comp_c_reg <= comp_c_next;
        end
        prod_reg <= prod_next;
        out_reg  <= out_next;
    end

    assign random_value = out_reg;

endmodule

// ===== rtl/core/ctrng_ctrl.sv =====
// Controller FSM: handshakes, seeding sequence, warm-up count.
// Depends on ctrng_pkg.
module ctrng_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_opcode,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output ctrng_pkg::cmd_t     cmd
);
    import ctrng_pkg::*;

    state_t             state_reg, state_next;
    logic [WarmW-1:0]   warm_cnt_reg, warm_cnt_next;
    logic               seeded_reg, seeded_next;
    logic               draw_pend_reg, draw_pend_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_free;

    assign out_free = !out_valid_reg || m_ready;

    always_comb begin
        state_next     = state_reg;
        warm_cnt_next  = warm_cnt_reg;
        seeded_next    = seeded_reg;
        draw_pend_next = draw_pend_reg;
        cmd            = '0;
        s_ready        = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = out_free;
                if (s_valid && out_free) begin
                    if (s_opcode == OP_RESEED || !seeded_reg) begin
                        cmd.mul_seed   = 1'b1;
                        draw_pend_next = (s_opcode == OP_DRAW);
                        state_next     = ST_SEED_A;
                    end else begin
                        cmd.advance  = 1'b1;
                        cmd.load_out = 1'b1;
                    end
                end
            end
            ST_SEED_A: begin
                cmd.load_a = 1'b1;
                state_next = ST_MUL_B;
            end
            ST_MUL_B: begin
                cmd.mul_a  = 1'b1;
                state_next = ST_SEED_B;
            end
            ST_SEED_B: begin
                cmd.load_b = 1'b1;
                state_next = ST_MUL_C;
            end
            ST_MUL_C: begin
                cmd.mul_b  = 1'b1;
                state_next = ST_SEED_C;
            end
            ST_SEED_C: begin
                cmd.load_c    = 1'b1;
                warm_cnt_next = '0;
                state_next    = ST_WARM;
            end
            ST_WARM: begin
                cmd.advance = 1'b1;
                if (warm_cnt_reg == WarmW'(WarmSteps - 1)) begin
                    seeded_next   = 1'b1;
                    warm_cnt_next = '0;
                    state_next    = draw_pend_reg ? ST_DRAW : ST_IDLE;
                end else begin
                    warm_cnt_next = warm_cnt_reg + 1'b1;
                end
            end
            ST_DRAW: begin
                // first draw after an implicit seed waits for the output slot
                if (out_free) begin
                    cmd.advance  = 1'b1;
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            warm_cnt_reg  <= '0;
            seeded_reg    <= 1'b0;
            draw_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            warm_cnt_reg  <= warm_cnt_next;
            seeded_reg    <= seeded_next;
            draw_pend_reg <= draw_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_valid = out_valid_reg;

endmodule

// ===== rtl/core/combined_tausworthe_rng_core.sv =====
// Top level of the combined Tausworthe (three-component) RNG core.
// Depends on ctrng_pkg, ctrng_ctrl, ctrng_dpath.
//
//  Channel  Dir  Handshake          Payload
//  s_       in   s_valid/s_ready    s_opcode (0 draw, 1 reseed), s_seed_value[31:0]
//  m_       out  m_valid/m_ready    m_random_value[31:0]
//
// A seeded draw's result is valid in the cycle after its accept; draws sustain
// one item per cycle while each result is taken. A reseed keeps s_ready low
// after its accept for three LCG passes through the single shared multiplier
// (each a multiply then a load) plus six warm-up steps counted by the controller.
// An unseeded draw then takes its own step. Reset (aresetn low, synchronous)
// clears the components and the seeded flag. A stalled result holds in the
// output register and blocks new items only until it is taken.
module combined_tausworthe_rng_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_opcode,
    input  logic [31:0] s_seed_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_random_value
);
    import ctrng_pkg::*;

    cmd_t cmd;

    ctrng_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_opcode (s_opcode),
        .s_ready  (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .cmd      (cmd)
    );

    ctrng_dpath u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .seed_value   (s_seed_value),
        .random_value (m_random_value)
    );

endmodule

// ===== rtl/core/ctrng_checker.sv =====
// Port-level checker for the RNG core, with its bind.
// Depends on ctrng_pkg and combined_tausworthe_rng_core_defines.svh.
`include "combined_tausworthe_rng_core_defines.svh"

module ctrng_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        s_opcode,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_random_value
);
    import ctrng_pkg::*;

    logic reseed_acc;
    assign reseed_acc = s_valid && s_ready && (s_opcode == OP_RESEED);

    // stalled result holds
    `CTRNG_ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_random_value))
    // a reseed starts the busy seeding sequence
    `CTRNG_ASSERT_NXT(a_reseed_busy, aclk, aresetn, reseed_acc, !s_ready)
    // a reseed item produces no result
    `CTRNG_ASSERT_NXT(a_reseed_no_out, aclk, aresetn, reseed_acc, !m_valid)
    // s_ready stays low into the warm-up steps after a reseed
    `CTRNG_ASSERT_IMP(a_reseed_warm, aclk, aresetn, reseed_acc, ##10 !s_ready)

endmodule

bind combined_tausworthe_rng_core ctrng_checker u_ctrng_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .s_opcode       (s_opcode),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_random_value (m_random_value)
);
